// ===== design/sfd_pkg.sv =====
// package: types and constants shared by the serial frame deframer modules
`timescale 1ns / 1ps

package sfd_pkg;

    localparam logic [7:0] SYNC_FIRST_RESET  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND_RESET = 8'h22;

    localparam logic CFG_SYNC_FIRST  = 1'b0;
    localparam logic CFG_SYNC_SECOND = 1'b1;

    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_FRAME_OK  = 2'd1,
        KIND_FRAME_BAD = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SYNC1 = 3'd1,
        PH_CMD   = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHECK = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0] ack_code;
        logic [7:0] payload_length;
        logic       ack_request;
        logic [6:0] command;
        logic [7:0] byte_index;
        logic [7:0] data_byte;
    } result_t;

endpackage

// ===== design/sfd_parser.sv =====
// frame parser: phase machine, running sums and result formation for one byte
`timescale 1ns / 1ps

module sfd_parser
    import sfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] byte_in,
    input  logic [7:0] sync_first,
    input  logic [7:0] sync_second,
    output logic       res_valid,
    output kind_t      res_kind,
    output result_t    res
);

    phase_t     phase_reg, phase_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] payload_count_reg, payload_count_next;
    logic [7:0] frame_sum_reg, frame_sum_next;
    logic [7:0] payload_sum_reg, payload_sum_next;
    logic [7:0] command_byte_reg, command_byte_next;
    logic [7:0] length_byte_reg, length_byte_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            bytes_left_reg    <= '0;
            payload_count_reg <= '0;
            frame_sum_reg     <= '0;
            payload_sum_reg   <= '0;
            command_byte_reg  <= '0;
            length_byte_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            bytes_left_reg    <= bytes_left_next;
            payload_count_reg <= payload_count_next;
            frame_sum_reg     <= frame_sum_next;
            payload_sum_reg   <= payload_sum_next;
            command_byte_reg  <= command_byte_next;
            length_byte_reg   <= length_byte_next;
        end
    end

    always_comb
    begin
        phase_next         = PH_IDLE;
        bytes_left_next    = bytes_left_reg;
        payload_count_next = payload_count_reg;
        frame_sum_next     = frame_sum_reg;
        payload_sum_next   = payload_sum_reg;
        command_byte_next  = command_byte_reg;
        length_byte_next   = length_byte_reg;
        res_valid          = 1'b0;
        res_kind           = KIND_PAYLOAD;
        res.data_byte      = byte_in;
        res.byte_index     = 8'd0;
        res.command        = command_byte_reg[6:0];
        res.ack_request    = command_byte_reg[7];
        res.payload_length = length_byte_reg;
        res.ack_code       = 8'd0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (byte_in == sync_first)
                begin
                    phase_next     = PH_SYNC1;
                    frame_sum_next = byte_in;
                end
            end
            PH_SYNC1:
            begin
                if (byte_in == sync_second)
                begin
                    phase_next     = PH_CMD;
                    frame_sum_next = frame_sum_reg + byte_in;
                end
            end
            PH_CMD:
            begin
                phase_next        = PH_LEN;
                command_byte_next = byte_in;
                frame_sum_next    = frame_sum_reg + byte_in;
            end
            PH_LEN:
            begin
                phase_next         = PH_DATA;
                length_byte_next   = byte_in;
                bytes_left_next    = byte_in;
                payload_count_next = 8'd0;
                payload_sum_next   = 8'd0;
                frame_sum_next     = frame_sum_reg + byte_in;
            end
            PH_DATA:
            begin
                // zero length frame falls through to idle
                if (bytes_left_reg != 8'd0)
                begin
                    bytes_left_next    = bytes_left_reg - 8'd1;
                    payload_count_next = payload_count_reg + 8'd1;
                    payload_sum_next   = payload_sum_reg + byte_in;
                    frame_sum_next     = frame_sum_reg + byte_in;
                    phase_next         = (bytes_left_reg == 8'd1) ? PH_CHECK : PH_DATA;
                    res_valid          = 1'b1;
                    res.byte_index     = payload_count_reg;
                end
            end
            PH_CHECK:
            begin
                res_valid    = 1'b1;
                res_kind     = (byte_in == frame_sum_reg) ? KIND_FRAME_OK : KIND_FRAME_BAD;
                res.ack_code = {1'b0, command_byte_reg[6:0]} + payload_sum_reg;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

endmodule

// ===== design/serial_frame_deframer_top.sv =====
// top level: serial frame deframer with input beat register and output register
//
// channel | dir | width | content
// s_axis  | in  | 8     | received serial byte, one per beat
// m_axis  | out | 40+2  | payload byte or frame-end result, kind on tuser
// cfg     | in  | 8     | sync_first (index 0), sync_second (index 1)
//
// one byte per cycle sustained while the output is not stalled; a payload or check
// byte passes from the input register through the parser into the output register
// reset returns the parser to idle and the sync bytes to 0xAA and 0x22
// a stalled output holds its beat; the input register advances whenever
// the output register is empty or being taken
`timescale 1ns / 1ps

module serial_frame_deframer_top
    import sfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // byte_in[7:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // data_byte[7:0], byte_index[15:8], command[22:16],
                                        // ack_request[23], payload_length[31:24],
                                        // ack_code[39:32]
    output logic [1:0]  m_axis_tuser,   // kind[1:0]
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_data
);

    logic [7:0] sync_first_reg;
    logic [7:0] sync_second_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_res_reg;
    kind_t      out_kind_reg;
    logic       advance;
    logic       res_valid;
    kind_t      res_kind;
    result_t    res;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RESET;
            sync_second_reg <= SYNC_SECOND_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                CFG_SYNC_SECOND: sync_second_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // input beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    sfd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .byte_in     (in_byte_reg),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .res_valid   (res_valid),
        .res_kind    (res_kind),
        .res         (res)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_reg <= advance && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_res_reg  <= res;
            out_kind_reg <= res_kind;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_res_reg;
    assign m_axis_tuser  = out_kind_reg;

endmodule
